### sv/bsl_pkg.sv
// Shared types and constants for the bisection subdomain locator.
// No dependencies; imported by the top level.
package bsl_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FIELD_W    = 16;
    localparam int RANK_IN_W  = 10;
    localparam int RCOUNT_W   = 11;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [1:0]           status_t;

    localparam cfg_idx_t CFG_GRID_X     = 2'd0;
    localparam cfg_idx_t CFG_GRID_Y     = 2'd1;
    localparam cfg_idx_t CFG_RANK_COUNT = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_EMPTY   = 2'd1;
    localparam status_t STATUS_INVALID = 2'd2;

endpackage

### sv/bsl_ceildiv.sv
// Shared multiply and ceiling-divide unit: quot = ceil(size * d / n).
// A multiply step and a load step, then one quotient bit per cycle.
// Standalone; instantiated by bisection_subdomain_locator_unit.
module bsl_ceildiv #(
    parameter int CW = 16,
    parameter int RW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [CW-1:0] size,
    input  logic [RW-1:0] d,
    input  logic [RW-1:0] n,
    output logic          done,
    output logic [CW-1:0] quot
);

    localparam int PW   = CW + RW;
    localparam int DW   = CW + RW + 1;
    localparam int CNTW = $clog2(CW + 1);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_MUL  = 4'b0010,
        D_LOAD = 4'b0100,
        D_DIV  = 4'b1000
    } div_state_t;

    div_state_t      state_reg, state_next;
    logic [CW-1:0]   size_reg, size_next;
    logic [RW-1:0]   d_reg, d_next;
    logic [RW-1:0]   n_reg, n_next;
    logic [PW-1:0]   prod_reg, prod_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   quot_reg, quot_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            done_reg, done_next;

    logic [DW-1:0]   dividend;
    logic [RW:0]     trial;
    logic [RW:0]     diff;

    assign dividend = DW'(prod_reg) + DW'(n_reg) - DW'(1);
    assign trial    = {rem_reg, quot_reg[CW-1]};
    assign diff     = trial - {1'b0, n_reg};

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    size_next  = size;
                    d_next     = d;
                    n_next     = n;
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                prod_next  = PW'(size_reg) * PW'(d_reg);
                state_next = D_LOAD;
            end
            D_LOAD:
            begin
                rem_next   = RW'(dividend >> CW);
                quot_next  = dividend[CW-1:0];
                cnt_next   = CNTW'(CW);
                state_next = D_DIV;
            end
            D_DIV:
            begin
                if (trial >= {1'b0, n_reg})
                begin
                    rem_next  = diff[RW-1:0];
                    quot_next = {quot_reg[CW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[RW-1:0];
                    quot_next = {quot_reg[CW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

### sv/bisection_subdomain_locator_unit.sv
// Bisection subdomain locator: one request at a time, busy while walking.
// Invalid and single-rank requests finish at the first check; other requests walk
// L <= ceil(log2(rank count)) levels, each through the shared bit-serial ceil divider.
// A new request can be taken in the cycle its predecessor's done strobe is high.
// Reset clears the sequencer, the done strobe, and sets the grid to 0x0 with one rank.
// Depends on bsl_pkg and bsl_ceildiv; results cannot be stalled.
module bisection_subdomain_locator_unit #(
    parameter int MAX_RANKS = 1024,
    parameter int CELL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bsl_pkg::RANK_IN_W-1:0]       rank_index,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  bsl_pkg::cfg_idx_t                   cfg_index,
    input  logic [bsl_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                done,
    output logic [bsl_pkg::FIELD_W-1:0]         origin_x,
    output logic [bsl_pkg::FIELD_W-1:0]         origin_y,
    output logic [bsl_pkg::FIELD_W-1:0]         extent_x,
    output logic [bsl_pkg::FIELD_W-1:0]         extent_y,
    output bsl_pkg::status_t                    status
);

    import bsl_pkg::*;

    localparam int CW = CELL_BITS;
    localparam int RW = $clog2(MAX_RANKS + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_WAIT  = 3'b100
    } seq_state_t;

    logic [FIELD_W-1:0]  gx_reg, gy_reg;
    logic [RCOUNT_W-1:0] rc_reg;

    seq_state_t    state_reg, state_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] n_reg, n_next;
    logic [CW-1:0] x0_reg, x0_next;
    logic [CW-1:0] y0_reg, y0_next;
    logic [CW-1:0] nx_reg, nx_next;
    logic [CW-1:0] ny_reg, ny_next;
    status_t       status_reg, status_next;
    logic          done_reg, done_next;

    logic [RW-1:0] n_sat;
    logic          rank_bad;
    logic [RW-1:0] half;
    logic          split_x;
    logic [CW-1:0] div_size;
    logic          div_start;
    logic          div_done;
    logic [CW-1:0] low;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
            rc_reg <= RCOUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_X:     gx_reg <= cfg_data;
                CFG_GRID_Y:     gy_reg <= cfg_data;
                CFG_RANK_COUNT: rc_reg <= cfg_data[RCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign n_sat    = (32'(rc_reg) > 32'(MAX_RANKS)) ? RW'(MAX_RANKS) : RW'(rc_reg);
    assign rank_bad = (32'(rank_index) >= 32'(n_sat));
    assign half     = n_reg >> 1;
    assign split_x  = (nx_reg >= ny_reg);
    assign div_size = split_x ? nx_reg : ny_reg;

    bsl_ceildiv #(
        .CW(CW),
        .RW(RW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .size  (div_size),
        .d     (half),
        .n     (n_reg),
        .done  (div_done),
        .quot  (low)
    );

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        n_next      = n_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    r_next      = RW'(rank_index);
                    n_next      = n_sat;
                    x0_next     = '0;
                    y0_next     = '0;
                    nx_next     = CW'(gx_reg);
                    ny_next     = CW'(gy_reg);
                    status_next = rank_bad ? STATUS_INVALID : STATUS_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status_reg == STATUS_INVALID)
                begin
                    x0_next    = '0;
                    y0_next    = '0;
                    nx_next    = '0;
                    ny_next    = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (n_reg < RW'(2))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (nx_reg < CW'(2) && ny_reg < CW'(2))
                begin
                    if (r_reg != '0)
                    begin
                        nx_next     = '0;
                        ny_next     = '0;
                        status_next = STATUS_EMPTY;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (r_reg < half)
                    begin
                        if (split_x)
                            nx_next = low;
                        else
                            ny_next = low;
                        n_next = half;
                    end
                    else
                    begin
                        r_next = r_reg - half;
                        if (split_x)
                        begin
                            x0_next = x0_reg + low;
                            nx_next = nx_reg - low;
                        end
                        else
                        begin
                            y0_next = y0_reg + low;
                            ny_next = ny_reg - low;
                        end
                        n_next = n_reg - half;
                    end
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        n_reg      <= n_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        status_reg <= status_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign origin_x = FIELD_W'(x0_reg);
    assign origin_y = FIELD_W'(y0_reg);
    assign extent_x = FIELD_W'(nx_reg);
    assign extent_y = FIELD_W'(ny_reg);
    assign status   = status_reg;

endmodule

### tb/tb_top.sv
// Self-checking bench for bisection_subdomain_locator_unit: directed table, then random phases.
// Expected: typed table rows, else an in-bench bisection walk over the programmed grid.
// Depends on bsl_pkg and the locator RTL.
module tb_top;
    import bsl_pkg::*;

    localparam int MAX_RANKS  = 1024;
    localparam int NUM_DIR    = 23;
    localparam int NUM_PHASES = 12;
    localparam int PHASE_REQS = 158;
    localparam int DRAIN_WAIT = 250;
    localparam int LIMIT      = 2000000;

    typedef struct packed {
        logic [FIELD_W-1:0] origin_x;
        logic [FIELD_W-1:0] origin_y;
        logic [FIELD_W-1:0] extent_x;
        logic [FIELD_W-1:0] extent_y;
        status_t            status;
    } rect_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] grid_x;
        logic [CFG_DATA_W-1:0] grid_y;
        logic [CFG_DATA_W-1:0] ranks;
        logic [RANK_IN_W-1:0]  rank;
        bit                    typed;
        rect_t                 want;
    } dir_row_t;

    localparam rect_t NO_RECT      = '0;
    localparam rect_t INVALID_RECT = '{16'd0, 16'd0, 16'd0, 16'd0, STATUS_INVALID};
    localparam rect_t EMPTY_RECT   = '{16'd0, 16'd0, 16'd0, 16'd0, STATUS_EMPTY};
    localparam rect_t ZERO_OK_RECT = '{16'd0, 16'd0, 16'd0, 16'd0, STATUS_OK};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [RANK_IN_W-1:0]  rank_index = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_GRID_X;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    logic [FIELD_W-1:0]    origin_x;
    logic [FIELD_W-1:0]    origin_y;
    logic [FIELD_W-1:0]    extent_x;
    logic [FIELD_W-1:0]    extent_y;
    status_t               status;

    logic [15:0]           grid_x_reg = 16'd0;
    logic [15:0]           grid_y_reg = 16'd0;
    logic [10:0]           ranks_reg = 11'd1;
    logic [CFG_DATA_W-1:0] ranks_data = 16'd1;

    rect_t                 pending_rects[$];
    int                    mismatches = 0;
    int                    cycles = 0;
    int                    n_requests = 0;
    int                    n_invalid = 0;
    int                    n_empty = 0;
    int                    n_settings = 0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{16'd0,     16'd0,     16'd1,     10'd0,    1'b1, ZERO_OK_RECT},
        '{16'd0,     16'd0,     16'd1,     10'd1,    1'b1, INVALID_RECT},
        '{16'd0,     16'd0,     16'd1,     10'd1023, 1'b1, INVALID_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd1024,  10'd0,    1'b0, NO_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd1024,  10'd1023, 1'b0, NO_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd1024,  10'd511,  1'b0, NO_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd0,     10'd0,    1'b1, INVALID_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd0,     10'd1023, 1'b1, INVALID_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd2047,  10'd1023, 1'b0, NO_RECT},
        '{16'hFFFF,  16'hFFFF,  16'd2047,  10'd0,    1'b0, NO_RECT},
        '{16'd1,     16'd1,     16'd4,     10'd0,    1'b1,
          '{16'd0, 16'd0, 16'd1, 16'd1, STATUS_OK}},
        '{16'd1,     16'd1,     16'd4,     10'd3,    1'b1, EMPTY_RECT},
        '{16'd0,     16'd0,     16'd8,     10'd5,    1'b1, EMPTY_RECT},
        '{16'd0,     16'd0,     16'd8,     10'd0,    1'b1, ZERO_OK_RECT},
        '{16'd3,     16'd1,     16'd8,     10'd7,    1'b0, NO_RECT},
        '{16'd3,     16'd1,     16'd8,     10'd1,    1'b0, NO_RECT},
        '{16'd64,    16'd64,    16'd2,     10'd1,    1'b0, NO_RECT},
        '{16'd100,   16'd50,    16'd3,     10'd2,    1'b0, NO_RECT},
        '{16'd1,     16'hFFFF,  16'd1024,  10'd777,  1'b0, NO_RECT},
        '{16'hFFFF,  16'd0,     16'd5,     10'd4,    1'b0, NO_RECT},
        '{16'hFFFF,  16'hFFFF,  16'hF801,  10'd0,    1'b1,
          '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, STATUS_OK}},
        '{16'hFFFF,  16'hFFFF,  16'hF801,  10'd1,    1'b1, INVALID_RECT},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  10'd600,  1'b0, NO_RECT}
    };

    bisection_subdomain_locator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rank_index (rank_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .extent_x   (extent_x),
        .extent_y   (extent_y),
        .status     (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned active_ranks();
        int unsigned n;
        n = ranks_reg;
        if (n > MAX_RANKS)
            n = MAX_RANKS;
        return n;
    endfunction

    function automatic rect_t locate_rect(logic [RANK_IN_W-1:0] rank);
        rect_t       res;
        int unsigned offset;
        int unsigned n;
        int unsigned half;
        int unsigned low;
        int unsigned x0;
        int unsigned y0;
        int unsigned nx;
        int unsigned ny;
        bit          split_x;
        bit          stuck;
        res = '0;
        n = active_ranks();
        offset = rank;
        if (offset >= n)
        begin
            res.status = STATUS_INVALID;
            return res;
        end
        x0 = 0;
        y0 = 0;
        nx = grid_x_reg;
        ny = grid_y_reg;
        stuck = 1'b0;
        res.status = STATUS_OK;
        while (n > 1 && !stuck)
        begin
            half = n / 2;
            if (nx < 2 && ny < 2)
            begin
                if (offset > 0)
                begin
                    nx = 0;
                    ny = 0;
                    res.status = STATUS_EMPTY;
                end
                stuck = 1'b1;
            end
            else
            begin
                split_x = (nx >= ny);
                low = ((split_x ? nx : ny) * half + n - 1) / n;
                if (offset < half)
                begin
                    if (split_x)
                        nx = low;
                    else
                        ny = low;
                    n = half;
                end
                else
                begin
                    offset -= half;
                    if (split_x)
                    begin
                        x0 += low;
                        nx -= low;
                    end
                    else
                    begin
                        y0 += low;
                        ny -= low;
                    end
                    n -= half;
                end
            end
        end
        res.origin_x = x0[FIELD_W-1:0];
        res.origin_y = y0[FIELD_W-1:0];
        res.extent_x = nx[FIELD_W-1:0];
        res.extent_y = ny[FIELD_W-1:0];
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_side();
        case ($urandom_range(4))
            0: return 16'($urandom_range(3));
            1: return 16'($urandom_range(40));
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_ranks();
        case ($urandom_range(6))
            0: return 16'($urandom);
            1: return 16'd1024;
            2: return 16'($urandom_range(2, 16));
            default: return 16'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [RANK_IN_W-1:0] pick_rank();
        int unsigned n;
        n = active_ranks();
        if (n > 0 && $urandom_range(99) < 85)
            return RANK_IN_W'($urandom_range(n - 1));
        return RANK_IN_W'($urandom);
    endfunction

    task automatic note_mismatch(string what, rect_t want, rect_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: want org (%0d,%0d) ext (%0d,%0d) st %0d, got org (%0d,%0d) ext (%0d,%0d) st %0d",
                     what, want.origin_x, want.origin_y, want.extent_x, want.extent_y,
                     want.status, got.origin_x, got.origin_y, got.extent_x, got.extent_y,
                     got.status);
    endtask

    always @(posedge clk)
    begin
        rect_t got;
        rect_t want;
        got = '{origin_x, origin_y, extent_x, extent_y, status};
        if (rst_n && done)
        begin
            if (pending_rects.size() == 0)
                note_mismatch("unexpected result", NO_RECT, got);
            else
            begin
                want = pending_rects.pop_front();
                if (got.origin_x !== want.origin_x || got.origin_y !== want.origin_y ||
                    got.extent_x !== want.extent_x || got.extent_y !== want.extent_y ||
                    got.status !== want.status)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("bisection_subdomain_locator_unit: mismatch");
            $finish;
        end
    end

    task automatic send_request(logic [RANK_IN_W-1:0] rank, int idle_pct, bit typed,
                                rect_t typed_rect);
        rect_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        rank_index <= rank;
        do
            @(posedge clk);
        while (busy);
        want = typed ? typed_rect : locate_rect(rank);
        pending_rects.insert(pending_rects.size(), want);
        n_requests++;
        if (want.status == STATUS_INVALID)
            n_invalid++;
        if (want.status == STATUS_EMPTY)
            n_empty++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GRID_X: grid_x_reg = data;
            CFG_GRID_Y: grid_y_reg = data;
            CFG_RANK_COUNT:
            begin
                ranks_reg = data[10:0];
                ranks_data = data;
            end
            default: ;
        endcase
    endtask

    task automatic program_grid(logic [CFG_DATA_W-1:0] gx, logic [CFG_DATA_W-1:0] gy,
                                logic [CFG_DATA_W-1:0] rc);
        write_reg(CFG_GRID_X, gx);
        write_reg(CFG_GRID_Y, gy);
        write_reg(CFG_RANK_COUNT, rc);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial
    begin
        int idle_table [3];
        idle_table = '{0, 73, 10};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            if (dir_rows[i].grid_x != grid_x_reg || dir_rows[i].grid_y != grid_y_reg ||
                dir_rows[i].ranks != ranks_data)
            begin
                drain();
                program_grid(dir_rows[i].grid_x, dir_rows[i].grid_y, dir_rows[i].ranks);
            end
            send_request(dir_rows[i].rank, 0, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: program_grid(16'hFFFF, 16'hFFFF, 16'd1024);
                1: program_grid(16'd5, 16'd7, 16'd1024);
                default: program_grid(pick_side(), pick_side(), pick_ranks());
            endcase
            for (int i = 0; i < PHASE_REQS; i++)
                send_request(pick_rank(), idle_table[phase % 3], 1'b0, NO_RECT);
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_rects.size() != 0)
        begin
            $display("%0d results never arrived", pending_rects.size());
            mismatches += pending_rects.size();
        end

        $display("ran %0d requests over %0d grid settings: %0d out of range, %0d empty",
                 n_requests, n_settings, n_invalid, n_empty);
        $display("%0d mismatching results in %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("bisection_subdomain_locator_unit: match");
        else
            $display("bisection_subdomain_locator_unit: mismatch");
        $finish;
    end
endmodule

### filelist.f
sv/bsl_pkg.sv
sv/bsl_ceildiv.sv
sv/bisection_subdomain_locator_unit.sv
tb/tb_top.sv
